FILE: rtl/core/texel_format_packer_macros.svh
// Assertion macros shared by the packer's RTL.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef TEXEL_FORMAT_PACKER_MACROS_SVH
`define TEXEL_FORMAT_PACKER_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define TFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("texel_format_packer: same-cycle check failed");

// Next-cycle implication, checked only while out of reset.
`define TFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("texel_format_packer: next-cycle check failed");

`endif

FILE: rtl/core/tfp_pkg.sv
package tfp_pkg;

  // Fixed field widths of the pixel and texel requests.
  localparam int unsigned CHANNEL_W    = 16;
  localparam int unsigned TILE_COORD_W = 3;
  localparam int unsigned TEXEL_W      = 32;
  localparam int unsigned TEXEL_BITS_W = 6;
  localparam int unsigned MORTON_W     = 6;
  localparam int unsigned FMT_W        = 4;

  // Defaults for the top-level parameters.
  localparam int unsigned QUANTUM_BITS_DEF     = 16;
  localparam int unsigned GAMMA_INDEX_BITS_DEF = 12;

  // Linear luminance in Q0.16, which reaches 65536 at full scale.
  localparam int unsigned LIN_W  = 17;
  localparam int unsigned PROD_W = 33;
  localparam int unsigned YSUM_W = 34;

  // Luma weights in Q0.16; they add up to exactly one.
  localparam logic [15:0] LUMA_WEIGHT_R = 16'd13937;
  localparam logic [15:0] LUMA_WEIGHT_G = 16'd46868;
  localparam logic [15:0] LUMA_WEIGHT_B = 16'd4731;
  localparam logic [15:0] HALF_Q16      = 16'd32768;

  // Format codes held in the format register.
  localparam logic [FMT_W-1:0] FMT_RGBA8888 = 4'd0;
  localparam logic [FMT_W-1:0] FMT_RGB888   = 4'd1;
  localparam logic [FMT_W-1:0] FMT_RGBA5551 = 4'd2;
  localparam logic [FMT_W-1:0] FMT_RGB565   = 4'd3;
  localparam logic [FMT_W-1:0] FMT_RGBA4444 = 4'd4;
  localparam logic [FMT_W-1:0] FMT_LA88     = 4'd5;
  localparam logic [FMT_W-1:0] FMT_HILO88   = 4'd6;
  localparam logic [FMT_W-1:0] FMT_L8       = 4'd7;
  localparam logic [FMT_W-1:0] FMT_A8       = 4'd8;
  localparam logic [FMT_W-1:0] FMT_LA44     = 4'd9;
  localparam logic [FMT_W-1:0] FMT_L4       = 4'd10;
  localparam logic [FMT_W-1:0] FMT_A4       = 4'd11;

  // Texel widths reported with each texel.
  localparam logic [TEXEL_BITS_W-1:0] TEXEL_BITS_32 = 6'd32;
  localparam logic [TEXEL_BITS_W-1:0] TEXEL_BITS_24 = 6'd24;
  localparam logic [TEXEL_BITS_W-1:0] TEXEL_BITS_16 = 6'd16;
  localparam logic [TEXEL_BITS_W-1:0] TEXEL_BITS_8  = 6'd8;
  localparam logic [TEXEL_BITS_W-1:0] TEXEL_BITS_4  = 6'd4;

  typedef struct packed {
    logic [CHANNEL_W-1:0]    red;
    logic [CHANNEL_W-1:0]    green;
    logic [CHANNEL_W-1:0]    blue;
    logic [CHANNEL_W-1:0]    alpha;
    logic [TILE_COORD_W-1:0] tile_x;
    logic [TILE_COORD_W-1:0] tile_y;
  } pixel_in_t;

  typedef struct packed {
    logic [TEXEL_W-1:0]      texel;
    logic [TEXEL_BITS_W-1:0] texel_bits;
    logic [MORTON_W-1:0]     morton_index;
    logic                    high_nibble;
  } texel_out_t;

  // What travels down the pipeline beside the luminance path.
  typedef struct packed {
    pixel_in_t           pix;
    logic [FMT_W-1:0]    fmt;
    logic [MORTON_W-1:0] morton;
  } stage_t;

endpackage

FILE: rtl/core/tfp_ram.sv
module tfp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/texel_format_packer.sv
// An accepted pixel passes s1_r, s2_r, s3_r, s4_r and the output register to out_valid.
// Throughput: one pixel per cycle unless out_stall or the table fill holds the input;
// the gamma table reads and luma multiply stages take a request each cycle adv is high.
// Reset (rst_n low, synchronous) clears the pipeline and sets the format to RGBA8888,
// then a fill of all 2^GAMMA_TABLE_INDEX_BITS table entries (4096 by default) follows,
// during which in_stall stays high; configuration writes are taken throughout.
`include "texel_format_packer_macros.svh"

module texel_format_packer
  import tfp_pkg::*;
#(
  parameter int unsigned QUANTUM_BITS           = QUANTUM_BITS_DEF,
  parameter int unsigned GAMMA_TABLE_INDEX_BITS = GAMMA_INDEX_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pixel_in_t        in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output texel_out_t       out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [FMT_W-1:0] cfg_data
);

  localparam int unsigned GB          = GAMMA_TABLE_INDEX_BITS;
  localparam int unsigned GAMMA_DEPTH = 1 << GB;
  localparam int unsigned FRAC_BITS   = 30;
  localparam logic [63:0] ONE_Q       = 64'd1 << FRAC_BITS;
  localparam logic [63:0] GAMMA_MAX   = 64'(GAMMA_DEPTH - 1);
  localparam logic [63:0] QUANT_MAX   = (64'd1 << QUANTUM_BITS) - 64'd1;
  localparam int unsigned ENC_PROD_W  = LIN_W + GB + 1;
  localparam int unsigned ENC_J_W     = ENC_PROD_W - 16;

  // ---------------------------------------------------------------------------
  // Table contents, worked out at elaboration in Q30 fixed point.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (ONE_Q >> 1)) >> FRAC_BITS;
  endfunction

  function automatic logic [63:0] powq(input logic [63:0] r, input int unsigned n);
    logic [63:0] p;
    p = r;
    for (int unsigned i = 1; i < n; i++) begin
      p = mulq(p, r);
    end
    return p;
  endfunction

  // Largest r in [0, 1.0] whose n-th power does not exceed t.
  function automatic logic [63:0] rootq(input logic [63:0] t, input int unsigned n);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd0;
    hi = ONE_Q;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (powq(mid, n) <= t) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // sRGB code to linear light in Q0.16.
  function automatic logic [LIN_W-1:0] lin_entry(input logic [63:0] idx);
    logic [63:0] s;
    logic [63:0] u;
    logic [63:0] w;
    logic [63:0] lin;
    s = (idx * ONE_Q + GAMMA_MAX / 64'd2) / GAMMA_MAX;
    if (s * 64'd100000 <= 64'd4045 * ONE_Q) begin
      lin = (64'd100 * s + 64'd646) / 64'd1292;
    end else begin
      u = (64'd1000 * s + 64'd55 * ONE_Q + 64'd527) / 64'd1055;
      if (u > ONE_Q) begin
        u = ONE_Q;
      end
      w   = rootq(u, 5);
      lin = mulq(mulq(u, u), mulq(w, w));
    end
    if (lin > ONE_Q) begin
      lin = ONE_Q;
    end
    return LIN_W'((lin + (64'd1 << 13)) >> 14);
  endfunction

  // Linear luminance code back to an sRGB quantum.
  function automatic logic [QUANTUM_BITS-1:0] enc_entry(input logic [63:0] j);
    logic [63:0] yq;
    logic [63:0] t;
    logic [63:0] off;
    logic [63:0] v;
    yq = (j * ONE_Q + GAMMA_MAX / 64'd2) / GAMMA_MAX;
    if (yq * 64'd10000000 <= 64'd31308 * ONE_Q) begin
      v = (64'd1292 * yq + 64'd50) / 64'd100;
    end else begin
      t   = 64'd1055 * powq(rootq(yq, 12), 5) + 64'd500;
      off = 64'd55 * ONE_Q;
      v   = (t > off) ? (t - off) / 64'd1000 : 64'd0;
    end
    if (v > ONE_Q) begin
      v = ONE_Q;
    end
    return QUANTUM_BITS'((v * QUANT_MAX + (ONE_Q >> 1)) >> FRAC_BITS);
  endfunction

  function automatic logic [GAMMA_DEPTH-1:0][LIN_W-1:0] build_lin_table();
    logic [GAMMA_DEPTH-1:0][LIN_W-1:0] tbl;
    for (int unsigned i = 0; i < GAMMA_DEPTH; i++) begin
      tbl[i] = lin_entry(64'(i));
    end
    return tbl;
  endfunction

  function automatic logic [GAMMA_DEPTH-1:0][QUANTUM_BITS-1:0] build_enc_table();
    logic [GAMMA_DEPTH-1:0][QUANTUM_BITS-1:0] tbl;
    for (int unsigned i = 0; i < GAMMA_DEPTH; i++) begin
      tbl[i] = enc_entry(64'(i));
    end
    return tbl;
  endfunction

  localparam logic [GAMMA_DEPTH-1:0][LIN_W-1:0]        LIN_TABLE = build_lin_table();
  localparam logic [GAMMA_DEPTH-1:0][QUANTUM_BITS-1:0] ENC_TABLE = build_enc_table();

  // ---------------------------------------------------------------------------
  // Signals
  // ---------------------------------------------------------------------------
  logic [FMT_W-1:0]        format_r;
  logic                    filling_r;
  logic [GB-1:0]           fill_cnt_r;
  logic                    adv;
  logic                    in_accept;
  logic [MORTON_W-1:0]     morton_nxt;
  logic [GB-1:0]           idx_red;
  logic [GB-1:0]           idx_green;
  logic [GB-1:0]           idx_blue;
  logic [LIN_W-1:0]        lin_red;
  logic [LIN_W-1:0]        lin_green;
  logic [LIN_W-1:0]        lin_blue;
  logic [LIN_W-1:0]        fill_lin;
  logic [QUANTUM_BITS-1:0] fill_enc;
  logic [QUANTUM_BITS-1:0] lum;
  logic                    v1_r;
  logic                    v2_r;
  logic                    v3_r;
  logic                    v4_r;
  logic                    out_valid_r;
  stage_t                  s1_r;
  stage_t                  s2_r;
  stage_t                  s3_r;
  stage_t                  s4_r;
  logic [PROD_W-1:0]       wred_r;
  logic [PROD_W-1:0]       wgrn_r;
  logic [PROD_W-1:0]       wblu_r;
  logic [YSUM_W-1:0]       ysum;
  logic [LIN_W-1:0]        y_r;
  logic [ENC_PROD_W-1:0]   enc_prod;
  logic [ENC_J_W-1:0]      enc_j;
  logic [GB-1:0]           enc_addr;
  texel_out_t              out_data_r;
  texel_out_t              out_data_nxt;

  // ---------------------------------------------------------------------------
  // Configuration and table fill
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r <= FMT_RGBA8888;
    end else if (cfg_valid && cfg_ready) begin
      format_r <= cfg_data;
    end
  end

  // The fill walks every table address once after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filling_r  <= 1'b1;
      fill_cnt_r <= '0;
    end else if (filling_r) begin
      fill_cnt_r <= fill_cnt_r + GB'(1);
      if (fill_cnt_r == GB'(GAMMA_DEPTH - 1)) begin
        filling_r <= 1'b0;
      end
    end
  end

  assign fill_lin = LIN_TABLE[fill_cnt_r];
  assign fill_enc = ENC_TABLE[fill_cnt_r];

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipeline moves whenever the output register can take a
  // request.
  // ---------------------------------------------------------------------------
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv || filling_r;
  assign in_accept = in_valid && !in_stall;

  // Z-order index: x and y bits interleaved, x in the lowest position.
  assign morton_nxt = {in_data.tile_y[2], in_data.tile_x[2], in_data.tile_y[1],
                       in_data.tile_x[1], in_data.tile_y[0], in_data.tile_x[0]};

  // Gamma table index: the top bits of the channel, or the channel padded with zeros
  // when the index is wider than the channel.
  always_comb begin
    logic [QUANTUM_BITS+GB-1:0] wide_r;
    logic [QUANTUM_BITS+GB-1:0] wide_g;
    logic [QUANTUM_BITS+GB-1:0] wide_b;
    wide_r    = {in_data.red[QUANTUM_BITS-1:0], {GB{1'b0}}};
    wide_g    = {in_data.green[QUANTUM_BITS-1:0], {GB{1'b0}}};
    wide_b    = {in_data.blue[QUANTUM_BITS-1:0], {GB{1'b0}}};
    idx_red   = wide_r[QUANTUM_BITS+GB-1 -: GB];
    idx_green = wide_g[QUANTUM_BITS+GB-1 -: GB];
    idx_blue  = wide_b[QUANTUM_BITS+GB-1 -: GB];
  end

  // ---------------------------------------------------------------------------
  // Gamma tables: one linearising copy per colour channel and one encoding table.
  // ---------------------------------------------------------------------------
  tfp_ram #(.WIDTH(LIN_W), .DEPTH(GAMMA_DEPTH)) u_lin_red (
    .clk     (clk),
    .wr_en   (filling_r),
    .wr_addr (fill_cnt_r),
    .wr_data (fill_lin),
    .rd_en   (adv),
    .rd_addr (idx_red),
    .rd_data (lin_red)
  );

  tfp_ram #(.WIDTH(LIN_W), .DEPTH(GAMMA_DEPTH)) u_lin_green (
    .clk     (clk),
    .wr_en   (filling_r),
    .wr_addr (fill_cnt_r),
    .wr_data (fill_lin),
    .rd_en   (adv),
    .rd_addr (idx_green),
    .rd_data (lin_green)
  );

  tfp_ram #(.WIDTH(LIN_W), .DEPTH(GAMMA_DEPTH)) u_lin_blue (
    .clk     (clk),
    .wr_en   (filling_r),
    .wr_addr (fill_cnt_r),
    .wr_data (fill_lin),
    .rd_en   (adv),
    .rd_addr (idx_blue),
    .rd_data (lin_blue)
  );

  tfp_ram #(.WIDTH(QUANTUM_BITS), .DEPTH(GAMMA_DEPTH)) u_enc (
    .clk     (clk),
    .wr_en   (filling_r),
    .wr_addr (fill_cnt_r),
    .wr_data (fill_enc),
    .rd_en   (adv),
    .rd_addr (enc_addr),
    .rd_data (lum)
  );

  // ---------------------------------------------------------------------------
  // Luminance path
  // ---------------------------------------------------------------------------
  // Weighted sum of the three linear channels, rounded back to Q0.16.
  assign ysum = YSUM_W'(wred_r) + YSUM_W'(wgrn_r) + YSUM_W'(wblu_r) + YSUM_W'(HALF_Q16);

  // Encoding table index, clamped to the top entry.
  assign enc_prod = ENC_PROD_W'(y_r) * ENC_PROD_W'(GAMMA_MAX[GB-1:0])
                  + ENC_PROD_W'(HALF_Q16);
  assign enc_j    = enc_prod[ENC_PROD_W-1:16];
  assign enc_addr = (enc_j > ENC_J_W'(GAMMA_MAX[GB-1:0])) ? GAMMA_MAX[GB-1:0]
                                                          : enc_j[GB-1:0];

  // ---------------------------------------------------------------------------
  // Pipeline registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.pix    <= in_data;
      s1_r.fmt    <= format_r;
      s1_r.morton <= morton_nxt;
      s2_r        <= s1_r;
      wred_r      <= PROD_W'(lin_red) * PROD_W'(LUMA_WEIGHT_R);
      wgrn_r      <= PROD_W'(lin_green) * PROD_W'(LUMA_WEIGHT_G);
      wblu_r      <= PROD_W'(lin_blue) * PROD_W'(LUMA_WEIGHT_B);
      s3_r        <= s2_r;
      y_r         <= ysum[LIN_W+15:16];
      s4_r        <= s3_r;
      out_data_r  <= out_data_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Texel packing; channels are truncated to their top bits.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [QUANTUM_BITS-1:0] r;
    logic [QUANTUM_BITS-1:0] g;
    logic [QUANTUM_BITS-1:0] b;
    logic [QUANTUM_BITS-1:0] a;
    r = s4_r.pix.red[QUANTUM_BITS-1:0];
    g = s4_r.pix.green[QUANTUM_BITS-1:0];
    b = s4_r.pix.blue[QUANTUM_BITS-1:0];
    a = s4_r.pix.alpha[QUANTUM_BITS-1:0];
    out_data_nxt.morton_index = s4_r.morton;
    out_data_nxt.high_nibble  = 1'b0;
    unique case (s4_r.fmt)
      FMT_RGB888: begin
        out_data_nxt.texel      = {8'd0, r[QUANTUM_BITS-1 -: 8], g[QUANTUM_BITS-1 -: 8],
                                   b[QUANTUM_BITS-1 -: 8]};
        out_data_nxt.texel_bits = TEXEL_BITS_24;
      end
      FMT_RGBA5551: begin
        out_data_nxt.texel      = {16'd0, r[QUANTUM_BITS-1 -: 5], g[QUANTUM_BITS-1 -: 5],
                                   b[QUANTUM_BITS-1 -: 5], a[QUANTUM_BITS-1]};
        out_data_nxt.texel_bits = TEXEL_BITS_16;
      end
      FMT_RGB565: begin
        out_data_nxt.texel      = {16'd0, r[QUANTUM_BITS-1 -: 5], g[QUANTUM_BITS-1 -: 6],
                                   b[QUANTUM_BITS-1 -: 5]};
        out_data_nxt.texel_bits = TEXEL_BITS_16;
      end
      FMT_RGBA4444: begin
        out_data_nxt.texel      = {16'd0, r[QUANTUM_BITS-1 -: 4], g[QUANTUM_BITS-1 -: 4],
                                   b[QUANTUM_BITS-1 -: 4], a[QUANTUM_BITS-1 -: 4]};
        out_data_nxt.texel_bits = TEXEL_BITS_16;
      end
      FMT_LA88: begin
        out_data_nxt.texel      = {16'd0, lum[QUANTUM_BITS-1 -: 8], a[QUANTUM_BITS-1 -: 8]};
        out_data_nxt.texel_bits = TEXEL_BITS_16;
      end
      FMT_HILO88: begin
        out_data_nxt.texel      = {16'd0, r[QUANTUM_BITS-1 -: 8], g[QUANTUM_BITS-1 -: 8]};
        out_data_nxt.texel_bits = TEXEL_BITS_16;
      end
      FMT_L8: begin
        out_data_nxt.texel      = {24'd0, lum[QUANTUM_BITS-1 -: 8]};
        out_data_nxt.texel_bits = TEXEL_BITS_8;
      end
      FMT_A8: begin
        out_data_nxt.texel      = {24'd0, a[QUANTUM_BITS-1 -: 8]};
        out_data_nxt.texel_bits = TEXEL_BITS_8;
      end
      FMT_LA44: begin
        out_data_nxt.texel      = {24'd0, lum[QUANTUM_BITS-1 -: 4], a[QUANTUM_BITS-1 -: 4]};
        out_data_nxt.texel_bits = TEXEL_BITS_8;
      end
      FMT_L4: begin
        out_data_nxt.texel       = {28'd0, lum[QUANTUM_BITS-1 -: 4]};
        out_data_nxt.texel_bits  = TEXEL_BITS_4;
        out_data_nxt.high_nibble = s4_r.morton[0];
      end
      FMT_A4: begin
        out_data_nxt.texel       = {28'd0, a[QUANTUM_BITS-1 -: 4]};
        out_data_nxt.texel_bits  = TEXEL_BITS_4;
        out_data_nxt.high_nibble = s4_r.morton[0];
      end
      // RGBA8888, and the unused codes, which pack the same way.
      default: begin
        out_data_nxt.texel      = {r[QUANTUM_BITS-1 -: 8], g[QUANTUM_BITS-1 -: 8],
                                   b[QUANTUM_BITS-1 -: 8], a[QUANTUM_BITS-1 -: 8]};
        out_data_nxt.texel_bits = TEXEL_BITS_32;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // No pixel may enter before the tables are loaded.
  `TFP_ASSERT_IMP(a_fill_blocks_input, filling_r, in_stall)
  // The table fill runs once per reset.
  `TFP_ASSERT_NXT(a_fill_once, !filling_r, !filling_r)
  // Only the 4-bit formats can place a texel in the upper nibble.
  `TFP_ASSERT_IMP(a_nibble_only_4bit, out_valid && out_data.high_nibble,
                  out_data.texel_bits == TEXEL_BITS_4)
  // A 16-bit texel leaves the upper half of the word clear.
  `TFP_ASSERT_IMP(a_texel16_upper_clear, out_valid && out_data.texel_bits == TEXEL_BITS_16,
                  out_data.texel[31:16] == 16'd0)

endmodule
